// ===== hw/rtl/ovca_pkg.sv =====
`default_nettype none

package ovca_pkg;

  // Fixed sizes of the allocator
  localparam int unsigned VC_SLOTS   = 64;
  localparam int unsigned VC_IDX_W   = 6;
  localparam int unsigned NUM_VNETS  = 4;
  localparam int unsigned NUM_DIMS   = 4;
  localparam int unsigned CREDIT_W   = 5;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  // Reset values of the configuration registers and of every credit counter
  localparam logic [4:0] VCS_PER_VNET_RST   = 5'd4;
  localparam logic [4:0] CREDITS_PER_VC_RST = 5'd4;
  localparam logic [CREDIT_W-1:0] CREDIT_RST = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VCS_PER_VNET   = 3'd0,
    REG_TOPOLOGY       = 3'd1,
    REG_ROUTING_MODE   = 3'd2,
    REG_PORT_IS_LOCAL  = 3'd3,
    REG_PORT_DIM       = 3'd4,
    REG_CREDITS_PER_VC = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_PROBE  = 2'd1,
    MODE_FLIT   = 2'd2,
    MODE_CREDIT = 2'd3
  } mode_e;

  localparam logic [1:0] TOPO_MESH  = 2'd0;
  localparam logic [1:0] TOPO_RING  = 2'd1;
  localparam logic [1:0] TOPO_TORUS = 2'd2;

  localparam logic [1:0] ROUTE_DOR      = 2'd0;
  localparam logic [1:0] ROUTE_ADAPTIVE = 2'd1;

  typedef struct packed {
    logic [4:0] vcs_per_vnet;
    logic [1:0] topology;
    logic [1:0] routing_mode;
    logic       port_is_local;
    logic [1:0] port_dim;
    logic [4:0] credits_per_vc;
  } cfg_t;

  typedef struct packed {
    logic                found;
    logic [VC_IDX_W-1:0] vc;
    logic [COUNT_W-1:0]  count;
  } srch_res_t;

  typedef struct packed {
    logic                ok;
    logic [CREDIT_W-1:0] level;
    logic                err;
  } cred_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ovca_if.sv =====
`default_nettype none

// Request word: allocate, probe, flit sent or credit returned
interface ovca_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] vnet;
  logic       ring_checkpoint;
  logic [3:0] dim_checkpoints;
  logic [5:0] vc_index;
  logic       free_signal;

  modport source (
    output valid, mode, vnet, ring_checkpoint, dim_checkpoints, vc_index, free_signal,
    input  ready
  );
  modport sink (
    input  valid, mode, vnet, ring_checkpoint, dim_checkpoints, vc_index, free_signal,
    output ready
  );
endinterface

// Response word: grant and credit status
interface ovca_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic [5:0] granted_vc;
  logic [4:0] free_count;
  logic       credit_ok;
  logic [4:0] credit_level;
  logic       credit_error;

  modport source (
    output valid, granted, granted_vc, free_count, credit_ok, credit_level, credit_error,
    input  ready
  );
  modport sink (
    input  valid, granted, granted_vc, free_count, credit_ok, credit_level, credit_error,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/ovca_ram.sv =====
`default_nettype none

module ovca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ovca_vc_search.sv =====
`default_nettype none

module ovca_vc_search import ovca_pkg::*; #(
  parameter int unsigned MAX_VCS = 16
) (
  input  wire logic [VC_SLOTS-1:0] idle_i,
  input  wire cfg_t                cfg_i,
  input  wire logic [1:0]          vnet_i,
  input  wire logic                ring_cp_i,
  input  wire logic [3:0]          dim_cps_i,
  output srch_res_t                res_o
);

  localparam int unsigned KW = (MAX_VCS > 1) ? $clog2(MAX_VCS) : 1;

  logic [5:0]          v;
  logic [5:0]          half, third, two3;
  logic [11:0]         third_p, two3_p;
  logic [7:0]          base;
  logic                cp;
  logic                w1_en, w2_en;
  logic [5:0]          lo1, hi1, lo2, hi2;
  logic [VC_SLOTS-1:0] shifted;
  logic [MAX_VCS-1:0]  cand;
  logic [KW-1:0]       first;
  logic [5:0]          cnt;
  logic [7:0]          gvc;

  // Clamp the VC count to 1..MAX_VCS
  always_comb begin
    if (cfg_i.vcs_per_vnet == 5'd0) begin
      v = 6'd1;
    end else if ({1'b0, cfg_i.vcs_per_vnet} > 6'(MAX_VCS)) begin
      v = 6'(MAX_VCS);
    end else begin
      v = {1'b0, cfg_i.vcs_per_vnet};
    end
  end

  // v/3 and 2v/3 by reciprocal multiply, exact for v up to 32
  assign third_p = 12'(v) * 12'd43;
  assign two3_p  = 12'(v) * 12'd86;
  assign half    = v >> 1;
  assign third   = 6'(third_p >> 7);
  assign two3    = 6'(two3_p >> 7);

  assign cp = (32'(cfg_i.port_dim) < NUM_DIMS) ? dim_cps_i[cfg_i.port_dim] : 1'b0;

  // Pick up to two windows, relative to the start of the vnet
  always_comb begin
    w1_en = 1'b0;
    w2_en = 1'b0;
    lo1   = '0;
    hi1   = '0;
    lo2   = '0;
    hi2   = '0;
    if (32'(vnet_i) < NUM_VNETS) begin
      case (cfg_i.topology)
        TOPO_RING: begin
          w1_en = 1'b1;
          lo1   = ring_cp_i ? 6'd0 : half;
          hi1   = ring_cp_i ? half : v;
        end
        TOPO_TORUS: begin
          if (cfg_i.port_is_local) begin
            w1_en = 1'b1;
            hi1   = v;
          end else if (cfg_i.routing_mode == ROUTE_ADAPTIVE) begin
            w1_en = 1'b1;
            hi1   = third;
            w2_en = 1'b1;
            lo2   = cp ? third : two3;
            hi2   = cp ? two3 : v;
          end else if (cfg_i.routing_mode == ROUTE_DOR) begin
            w1_en = 1'b1;
            lo1   = cp ? 6'd0 : half;
            hi1   = cp ? half : v;
          end
        end
        default: begin
          w1_en = 1'b1;
          hi1   = v;
        end
      endcase
    end
  end

  assign base    = 8'(vnet_i) * 8'(v);
  assign shifted = idle_i >> base;

  always_comb begin
    for (int k = 0; k < MAX_VCS; k++) begin
      cand[k] = shifted[k] &
                ((w1_en && (6'(k) >= lo1) && (6'(k) < hi1)) ||
                 (w2_en && (6'(k) >= lo2) && (6'(k) < hi2)));
    end
  end

  // Lowest idle candidate and population count
  always_comb begin
    first = '0;
    cnt   = '0;
    for (int k = MAX_VCS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        first = KW'(k);
      end
    end
    for (int k = 0; k < MAX_VCS; k++) begin
      cnt = cnt + 6'(cand[k]);
    end
  end

  assign gvc = base + 8'(first);

  assign res_o.found = |cand;
  assign res_o.vc    = (|cand) ? gvc[VC_IDX_W-1:0] : '0;
  assign res_o.count = cnt[5] ? 5'd31 : cnt[4:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ovca_credit.sv =====
`default_nettype none

module ovca_credit import ovca_pkg::*; (
  input  wire logic [1:0]          mode_i,
  input  wire logic [CREDIT_W-1:0] cur_i,
  input  wire logic [4:0]          credits_per_vc_i,
  output cred_res_t                res_o
);

  logic [CREDIT_W-1:0] maxc;
  logic [CREDIT_W-1:0] nxt;
  logic                err;

  assign maxc = (credits_per_vc_i == 5'd0) ? 5'd1 : credits_per_vc_i;

  // Saturate at zero on a flit, at the maximum on a return
  always_comb begin
    nxt = cur_i;
    err = 1'b0;
    if (mode_i == MODE_FLIT) begin
      if (cur_i == '0) begin
        err = 1'b1;
      end else begin
        nxt = cur_i - 5'd1;
      end
    end else begin
      if (cur_i >= maxc) begin
        err = 1'b1;
      end else begin
        nxt = cur_i + 5'd1;
      end
    end
  end

  assign res_o.ok    = (nxt != '0);
  assign res_o.level = nxt;
  assign res_o.err   = err;

endmodule

`default_nettype wire

// ===== hw/rtl/output_vc_allocator_with_credits.sv =====
`default_nettype none

// Channel    Dir  Handshake     Word
// in_i       in   valid/ready   mode, vnet, checkpoints, vc_index, free_signal
// out_o      out  valid/ready   granted, granted_vc, free_count, credit fields
// cfg        in   cfg_we_i      cfg_idx_i selects the register, cfg_wdata_i
//
// One word per cycle while the output is not stalled. A word passes the work
// stage, where the VC search or the credit update runs against the state,
// and then the output register. The credit RAM's read is registered and
// lines up with the work stage; one bypass register covers a fresh write.
// Reset is asynchronous; credits read their reset value through valid bits,
// so there is no clearing pass. A stalled output holds the work stage.

module output_vc_allocator_with_credits import ovca_pkg::*; #(
  parameter int unsigned MAX_VCS_PER_VNET = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ovca_req_if.sink                   in_i,
  ovca_rsp_if.source                 out_o
);

  cfg_t cfg_q;

  // Work stage
  logic                s1_valid_q;
  logic [1:0]          s1_mode_q;
  logic [1:0]          s1_vnet_q;
  logic                s1_ring_cp_q;
  logic [3:0]          s1_dim_cps_q;
  logic [VC_IDX_W-1:0] s1_vc_q;
  logic                s1_free_q;

  // Bypass for a credit written at the edge that read this word's entry
  logic                byp_hit_q;
  logic [CREDIT_W-1:0] byp_data_q;

  logic [VC_SLOTS-1:0] vc_active_q, vc_active_d;
  logic [VC_SLOTS-1:0] cred_vld_q;

  logic                out_valid_q;
  srch_res_t           out_srch_q;
  cred_res_t           out_cred_q;

  logic                accept, s1_adv, s1_is_cred, cred_wr;
  logic [CREDIT_W-1:0] ram_rdata, cur_credit;
  srch_res_t           srch;
  cred_res_t           cred;

  assign accept     = in_i.valid && in_i.ready;
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign s1_is_cred = (s1_mode_q == MODE_FLIT) || (s1_mode_q == MODE_CREDIT);
  assign cred_wr    = s1_adv && s1_is_cred;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vcs_per_vnet   <= VCS_PER_VNET_RST;
      cfg_q.topology       <= TOPO_MESH;
      cfg_q.routing_mode   <= ROUTE_DOR;
      cfg_q.port_is_local  <= 1'b0;
      cfg_q.port_dim       <= 2'd0;
      cfg_q.credits_per_vc <= CREDITS_PER_VC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VCS_PER_VNET:   cfg_q.vcs_per_vnet   <= cfg_wdata_i[4:0];
        REG_TOPOLOGY:       cfg_q.topology       <= cfg_wdata_i[1:0];
        REG_ROUTING_MODE:   cfg_q.routing_mode   <= cfg_wdata_i[1:0];
        REG_PORT_IS_LOCAL:  cfg_q.port_is_local  <= cfg_wdata_i[0];
        REG_PORT_DIM:       cfg_q.port_dim       <= cfg_wdata_i[1:0];
        REG_CREDITS_PER_VC: cfg_q.credits_per_vc <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming word into the work stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        byp_hit_q  <= cred_wr && (s1_vc_q == in_i.vc_index);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q    <= in_i.mode;
      s1_vnet_q    <= in_i.vnet;
      s1_ring_cp_q <= in_i.ring_checkpoint;
      s1_dim_cps_q <= in_i.dim_checkpoints;
      s1_vc_q      <= in_i.vc_index;
      s1_free_q    <= in_i.free_signal;
      byp_data_q   <= cred.level;
    end
  end

  // Credit store: read at acceptance, written back when the word leaves
  ovca_ram #(
    .WIDTH (CREDIT_W),
    .DEPTH (VC_SLOTS)
  ) u_cred_ram (
    .clk_i   (clk_i),
    .we_i    (cred_wr),
    .waddr_i (s1_vc_q),
    .wdata_i (cred.level),
    .re_i    (accept),
    .raddr_i (in_i.vc_index),
    .rdata_o (ram_rdata)
  );

  // Newest value first, then the RAM, else the reset credit
  always_comb begin
    if (byp_hit_q) begin
      cur_credit = byp_data_q;
    end else if (cred_vld_q[s1_vc_q]) begin
      cur_credit = ram_rdata;
    end else begin
      cur_credit = CREDIT_RST;
    end
  end

  ovca_credit u_credit (
    .mode_i           (s1_mode_q),
    .cur_i            (cur_credit),
    .credits_per_vc_i (cfg_q.credits_per_vc),
    .res_o            (cred)
  );

  ovca_vc_search #(
    .MAX_VCS (MAX_VCS_PER_VNET)
  ) u_search (
    .idle_i    (~vc_active_q),
    .cfg_i     (cfg_q),
    .vnet_i    (s1_vnet_q),
    .ring_cp_i (s1_ring_cp_q),
    .dim_cps_i (s1_dim_cps_q),
    .res_o     (srch)
  );

  // Mark an allocated VC busy; a returned credit with free makes it idle
  always_comb begin
    vc_active_d = vc_active_q;
    if (s1_adv) begin
      if ((s1_mode_q == MODE_ALLOC) && srch.found) begin
        vc_active_d[srch.vc] = 1'b1;
      end
      if ((s1_mode_q == MODE_CREDIT) && s1_free_q) begin
        vc_active_d[s1_vc_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_active_q <= '0;
      cred_vld_q  <= '0;
    end else begin
      vc_active_q <= vc_active_d;
      if (cred_wr) begin
        cred_vld_q[s1_vc_q] <= 1'b1;
      end
    end
  end

  // Output register; the unused half of the word is zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_srch_q <= s1_is_cred ? '0 : srch;
      out_cred_q <= s1_is_cred ? cred : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.granted      = out_srch_q.found;
  assign out_o.granted_vc   = out_srch_q.vc;
  assign out_o.free_count   = out_srch_q.count;
  assign out_o.credit_ok    = out_cred_q.ok;
  assign out_o.credit_level = out_cred_q.level;
  assign out_o.credit_error = out_cred_q.err;

  // A granted VC must be idle when the search reports it
  a_grant_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && srch.found |-> !vc_active_q[srch.vc])
    else $error("granted VC is already active");

  // An allocation leaves its VC active
  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_mode_q == MODE_ALLOC) && srch.found |=> vc_active_q[$past(srch.vc)])
    else $error("allocated VC not marked active");

  // A bypass hit only follows a write to the same entry
  a_byp_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && byp_hit_q |-> cred_vld_q[s1_vc_q])
    else $error("credit bypass without prior write");

  // A successful return never passes the maximum credit
  a_cred_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_mode_q == MODE_CREDIT) && !cred.err |->
      (cred.level <= cfg_q.credits_per_vc) || (cred.level == 5'd1))
    else $error("credit above maximum");

endmodule

`default_nettype wire

// ===== dv/ovca_tb_pkg.sv =====
package ovca_tb_pkg;
  import ovca_pkg::*;

  // Must match the MAX_VCS_PER_VNET the allocator is built with
  localparam int unsigned VC_CAP = 16;

  // Codes the RTL package leaves unnamed
  localparam logic [1:0] TOPO_SPARE  = 2'd3;
  localparam logic [1:0] ROUTE_OTHER = 2'd2;
  localparam logic [1:0] ROUTE_UNDEF = 2'd3;

  typedef struct packed {
    mode_e               mode;
    logic [1:0]          vnet;
    logic                ring_cp;
    logic [3:0]          dim_cps;
    logic [VC_IDX_W-1:0] vc;
    logic                free_sig;
  } alloc_req_t;

  typedef struct packed {
    logic                granted;
    logic [VC_IDX_W-1:0] vc;
    logic [COUNT_W-1:0]  free_count;
    logic                credit_ok;
    logic [CREDIT_W-1:0] level;
    logic                credit_err;
  } alloc_rsp_t;

  // Shadow of the VC busy bits and credit counters, plus the grant/credit
  // status words still owed by the allocator.
  class vc_ledger;
    cfg_t                cfg;
    bit                  active[VC_SLOTS];
    logic [CREDIT_W-1:0] credits[VC_SLOTS];
    alloc_rsp_t          due_status[$];
    int unsigned         errors;

    function new();
      cfg = '{vcs_per_vnet: VCS_PER_VNET_RST, topology: TOPO_MESH, routing_mode: ROUTE_DOR,
              port_is_local: 1'b0, port_dim: 2'd0, credits_per_vc: CREDITS_PER_VC_RST};
      foreach (active[i]) begin
        active[i]  = 1'b0;
        credits[i] = CREDIT_RST;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_VCS_PER_VNET:   cfg.vcs_per_vnet   = val;
        REG_TOPOLOGY:       cfg.topology       = val[1:0];
        REG_ROUTING_MODE:   cfg.routing_mode   = val[1:0];
        REG_PORT_IS_LOCAL:  cfg.port_is_local  = val[0];
        REG_PORT_DIM:       cfg.port_dim       = val[1:0];
        REG_CREDITS_PER_VC: cfg.credits_per_vc = val;
        default: ;
      endcase
    endfunction

    // VC slots base+lo .. base+hi-1 that exist
    function logic [VC_SLOTS-1:0] span(int unsigned base, int unsigned lo, int unsigned hi);
      logic [VC_SLOTS-1:0] m;
      m = '0;
      for (int unsigned k = lo; k < hi; k++)
        if (base + k < VC_SLOTS) m[base + k] = 1'b1;
      return m;
    endfunction

    function alloc_rsp_t predict_status(alloc_req_t w);
      alloc_rsp_t          r;
      logic [VC_SLOTS-1:0] window;
      int unsigned         v, base, cnt, maxc, c;
      int                  first;
      bit                  cp;
      r      = '0;
      window = '0;
      first  = -1;
      cnt    = 0;
      if (w.mode == MODE_ALLOC || w.mode == MODE_PROBE) begin
        v = cfg.vcs_per_vnet;
        if (v == 0) v = 1;
        if (v > VC_CAP) v = VC_CAP;
        base = w.vnet * v;
        cp   = (cfg.port_dim < NUM_DIMS) ? w.dim_cps[cfg.port_dim] : 1'b0;
        case (cfg.topology)
          TOPO_RING:
            window = w.ring_cp ? span(base, 0, v / 2) : span(base, v / 2, v);
          TOPO_TORUS: begin
            if (cfg.port_is_local)
              window = span(base, 0, v);
            else if (cfg.routing_mode == ROUTE_ADAPTIVE)
              window = span(base, 0, v / 3) |
                       (cp ? span(base, v / 3, v * 2 / 3) : span(base, v * 2 / 3, v));
            else if (cfg.routing_mode == ROUTE_DOR)
              window = cp ? span(base, 0, v / 2) : span(base, v / 2, v);
          end
          default: window = span(base, 0, v);
        endcase
        for (int i = 0; i < VC_SLOTS; i++) begin
          if (window[i] && !active[i]) begin
            if (first < 0) first = i;
            cnt++;
          end
        end
        if (cnt > 31) cnt = 31;
        if (first >= 0) begin
          r.granted = 1'b1;
          r.vc      = VC_IDX_W'(first);
          if (w.mode == MODE_ALLOC) active[first] = 1'b1;
        end
        r.free_count = COUNT_W'(cnt);
      end else begin
        maxc = (cfg.credits_per_vc == 0) ? 1 : cfg.credits_per_vc;
        c    = credits[w.vc];
        if (w.mode == MODE_FLIT) begin
          if (c == 0) r.credit_err = 1'b1;
          else c--;
        end else begin
          if (c >= maxc) r.credit_err = 1'b1;
          else c++;
          if (w.free_sig) active[w.vc] = 1'b0;
        end
        credits[w.vc] = CREDIT_W'(c);
        r.credit_ok   = (c > 0);
        r.level       = CREDIT_W'(c);
      end
      return r;
    endfunction

    function void take_request(alloc_req_t w);
      due_status.push_back(predict_status(w));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_response(alloc_rsp_t got);
      alloc_rsp_t want;
      if (due_status.size() == 0) begin
        $display("%0t: status word with none expected, expected none actual %p", $time, got);
        errors++;
        return;
      end
      want = due_status.pop_front();
      compare_field("granted", want.granted, got.granted);
      compare_field("granted_vc", want.vc, got.vc);
      compare_field("free_count", want.free_count, got.free_count);
      compare_field("credit_ok", want.credit_ok, got.credit_ok);
      compare_field("credit_level", want.level, got.level);
      compare_field("credit_error", want.credit_err, got.credit_err);
    endfunction

    function int unsigned pending();
      return due_status.size();
    endfunction

    // A busy VC at random, or -1 when every VC is idle
    function int pick_active_vc();
      int live[$];
      foreach (active[i]) if (active[i]) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ovca_pkg::*;
  import ovca_tb_pkg::*;

  // Generous limit on the length of the run
  localparam int unsigned RUN_LIMIT = 800_000;
  // Output hold-off that lets the pipeline fill and push back on the input
  localparam int unsigned HOLD_OFF  = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ovca_req_if req_ch ();
  ovca_rsp_if rsp_ch ();

  vc_ledger    ledger = new();
  bit          no_idle = 1'b0;     // phase without gaps on either side
  bit          starve_req = 1'b0;  // ask the response side for one long hold-off
  int unsigned cycles = 0;

  output_vc_allocator_with_credits #(
    .MAX_VCS_PER_VNET (VC_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_ch.sink),
    .out_o       (rsp_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: give up if the run hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Length of one gap: mostly a few cycles, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic alloc_req_t word_of(mode_e m, int unsigned vnet, bit ring_cp,
                                         logic [3:0] cps, int unsigned vc, bit free_sig);
    alloc_req_t w;
    w.mode     = m;
    w.vnet     = 2'(vnet);
    w.ring_cp  = ring_cp;
    w.dim_cps  = cps;
    w.vc       = VC_IDX_W'(vc);
    w.free_sig = free_sig;
    return w;
  endfunction

  function automatic cfg_t settings(int unsigned vcs, logic [1:0] topo, logic [1:0] route,
                                    bit is_local, int unsigned dim, int unsigned cpv);
    cfg_t c;
    c.vcs_per_vnet   = 5'(vcs);
    c.topology       = topo;
    c.routing_mode   = route;
    c.port_is_local  = is_local;
    c.port_dim       = 2'(dim);
    c.credits_per_vc = 5'(cpv);
    return c;
  endfunction

  // Mostly sensible port setups; now and then zero or oversized VC counts
  function automatic cfg_t random_settings();
    int unsigned vcs, cpv;
    vcs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
    cpv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
    return settings(vcs, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0), $urandom_range(0, 3), cpv);
  endfunction

  // Mostly traffic on VCs that are actually held, so credits run dry and
  // come back and VCs get released and reused; the rest is random noise.
  function automatic alloc_req_t random_word();
    alloc_req_t  w;
    int unsigned pick;
    int          held;
    w.vnet     = 2'($urandom_range(0, 3));
    w.ring_cp  = 1'($urandom_range(0, 1));
    w.dim_cps  = 4'($urandom_range(0, 15));
    w.vc       = VC_IDX_W'($urandom_range(0, 63));
    w.free_sig = ($urandom_range(0, 99) < 40);
    pick = $urandom_range(0, 99);
    if (pick < 30)      w.mode = MODE_ALLOC;
    else if (pick < 45) w.mode = MODE_PROBE;
    else if (pick < 75) w.mode = MODE_FLIT;
    else                w.mode = MODE_CREDIT;
    if (w.mode == MODE_FLIT || w.mode == MODE_CREDIT) begin
      held = ledger.pick_active_vc();
      if (held >= 0 && $urandom_range(0, 3) != 0) w.vc = VC_IDX_W'(held);
    end
    return w;
  endfunction

  // Offer one word and hold it until the allocator takes it
  task automatic send_word(input alloc_req_t w);
    req_ch.valid           <= 1'b1;
    req_ch.mode            <= w.mode;
    req_ch.vnet            <= w.vnet;
    req_ch.ring_checkpoint <= w.ring_cp;
    req_ch.dim_checkpoints <= w.dim_cps;
    req_ch.vc_index        <= w.vc;
    req_ch.free_signal     <= w.free_sig;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    ledger.take_request(w);
  endtask

  // Drop valid for a while, unless this phase runs flat out
  task automatic idle_after();
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      gap = gap_len();
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait for every owed status word
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  // Write all six registers back to back; the allocator is idle here
  task automatic apply_settings(input cfg_t c);
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] val;
    for (int i = 0; i <= REG_CREDITS_PER_VC; i++) begin
      idx = cfg_reg_e'(i);
      case (idx)
        REG_VCS_PER_VNET:   val = c.vcs_per_vnet;
        REG_TOPOLOGY:       val = {3'b000, c.topology};
        REG_ROUTING_MODE:   val = {3'b000, c.routing_mode};
        REG_PORT_IS_LOCAL:  val = {4'b0000, c.port_is_local};
        REG_PORT_DIM:       val = {3'b000, c.port_dim};
        default:            val = c.credits_per_vc;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= val;
      @(posedge clk_i);
      ledger.set_reg(idx, val);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input cfg_t c, input int unsigned words, input bit starve);
    apply_settings(c);
    // A starved phase sends flat out so the pipeline really backs up
    no_idle = starve || ($urandom_range(0, 3) == 0);
    if (starve) starve_req = 1'b1;
    repeat (words) begin
      send_word(random_word());
      idle_after();
    end
    drain();
  endtask

  // Response side: check every accepted status word, then pick the next
  // ready level; one step, one assignment to ready.
  initial begin : rsp_side
    int unsigned stall_left;
    alloc_rsp_t  got;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.granted    = rsp_ch.granted;
        got.vc         = rsp_ch.granted_vc;
        got.free_count = rsp_ch.free_count;
        got.credit_ok  = rsp_ch.credit_ok;
        got.level      = rsp_ch.credit_level;
        got.credit_err = rsp_ch.credit_error;
        ledger.match_response(got);
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (starve_req) begin
        // Long hold-off, counted here, while the request side keeps pushing
        starve_req = 1'b0;
        stall_left = HOLD_OFF - 1;
        rsp_ch.ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 75) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall_left = gap_len() - 1;
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    cfg_t corner[$];
    // Hold every input at a known level from the first instant
    rst_ni = 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= REG_VCS_PER_VNET;
    cfg_wdata_i            <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.mode            <= MODE_PROBE;
    req_ch.vnet            <= '0;
    req_ch.ring_checkpoint <= 1'b0;
    req_ch.dim_checkpoints <= '0;
    req_ch.vc_index        <= '0;
    req_ch.free_signal     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset setup (mesh, four VCs per vnet, four credits).
    // Probe every vnet with all the don't-care bits set.
    for (int vn = 0; vn < NUM_VNETS; vn++)
      send_word(word_of(MODE_PROBE, vn, 1'b1, 4'hF, 63, 1'b1));
    // Take all of vnet 0, then one more that must find nothing
    repeat (5) send_word(word_of(MODE_ALLOC, 0, 1'b0, 4'h0, 0, 1'b0));
    send_word(word_of(MODE_ALLOC, 3, 1'b1, 4'hA, 0, 1'b0));
    // Drain the top VC's credits and go one past zero
    repeat (5) send_word(word_of(MODE_FLIT, 0, 1'b0, 4'h0, 63, 1'b0));
    send_word(word_of(MODE_CREDIT, 0, 1'b0, 4'h0, 63, 1'b1));
    // Return a credit to a full counter, freeing VC 0, and probe it back
    send_word(word_of(MODE_CREDIT, 2, 1'b1, 4'h5, 0, 1'b1));
    send_word(word_of(MODE_PROBE, 0, 1'b0, 4'h0, 0, 1'b0));
    send_word(word_of(MODE_ALLOC, 0, 1'b0, 4'h0, 0, 1'b0));
    drain();

    // Corner setups: single VC, empty ring window, torus halves and thirds,
    // local port, routing modes with no window, spare topology, zero and
    // oversized VC counts, zero and full-range credit limits.
    corner.push_back(settings(1,  TOPO_MESH,  ROUTE_DOR,      1'b0, 0, 1));
    corner.push_back(settings(1,  TOPO_RING,  ROUTE_DOR,      1'b0, 0, 16));
    corner.push_back(settings(16, TOPO_RING,  ROUTE_ADAPTIVE, 1'b0, 1, 2));
    corner.push_back(settings(16, TOPO_TORUS, ROUTE_DOR,      1'b0, 3, 31));
    corner.push_back(settings(3,  TOPO_TORUS, ROUTE_ADAPTIVE, 1'b0, 2, 3));
    corner.push_back(settings(16, TOPO_TORUS, ROUTE_ADAPTIVE, 1'b1, 0, 4));
    corner.push_back(settings(8,  TOPO_TORUS, ROUTE_OTHER,    1'b0, 1, 0));
    corner.push_back(settings(5,  TOPO_TORUS, ROUTE_UNDEF,    1'b0, 0, 5));
    corner.push_back(settings(0,  TOPO_SPARE, ROUTE_ADAPTIVE, 1'b1, 3, 1));
    corner.push_back(settings(31, TOPO_MESH,  ROUTE_DOR,      1'b0, 0, 0));
    foreach (corner[i])
      run_phase(corner[i], 40, (i == 2));

    // Random setups, one of them under a long output stall
    for (int p = 0; p < 10; p++)
      run_phase(random_settings(), 60, (p == 4));

    // Let the pipeline settle before the verdict
    repeat (8) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
